[sv/cfr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types and constants of the command frame receiver: transaction
// structs, event and error codes, frame layout and command bytes.
// ----------------------------------------------------------------------------
package cfr_pkg;

  localparam int FRAME_BYTES = 7;
  localparam int CNT_W       = $clog2(FRAME_BYTES);
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_BYTES - 1);

  typedef logic [7:0] byte_t;
  typedef byte_t [FRAME_BYTES-1:0] frame_t;

  // frame layout and command bytes
  localparam byte_t HDR_FIRST    = 8'h07;
  localparam byte_t HDR_SECOND   = 8'hE0;
  localparam byte_t CMD_ERASE    = 8'hF0;
  localparam byte_t CMD_CAPACITY = 8'hF1;
  localparam byte_t CMD_DATA     = 8'hFF;
  localparam byte_t FLAG_OK      = 8'h01;
  localparam byte_t FLAG_FAIL    = 8'h02;

  // fault erase key: (seed * KEY_MUL + KEY_ADD) mod 2^16
  localparam logic [15:0] KEY_MUL = 16'h9164;
  localparam logic [15:0] KEY_ADD = 16'h1665;

  // configuration register indexes
  typedef enum logic {
    REG_SLAVE_ADDR = 1'b0,
    REG_KEY_SEED   = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    EVT_REJECT   = 3'd0,
    EVT_REPORT   = 3'd1,
    EVT_CLEARED  = 3'd2,
    EVT_CAPACITY = 3'd3,
    EVT_MISMATCH = 3'd4,
    EVT_IGNORED  = 3'd5
  } evt_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_HEADER   = 2'd1,
    ERR_ADDRESS  = 2'd2,
    ERR_CHECKSUM = 2'd3
  } err_t;

  typedef struct packed {
    byte_t rx_byte;
    logic  burst_end;
  } in_t;

  typedef struct packed {
    evt_t        event_res;
    err_t        error_code;
    logic [15:0] capacity_value;
    logic        tx_valid;
    byte_t       tx_byte;
    logic        last;
  } out_t;

  // decoded frame: what the emitter sends
  typedef struct packed {
    evt_t        event_res;
    err_t        error_code;
    logic [15:0] capacity_value;
    logic        rsp;
    frame_t      tx;
  } desc_t;

endpackage
`default_nettype wire

[sv/cfr_collect.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_collect
// Collects received bytes into a frame, drops the rest of a burst after a
// frame completes, and holds the completed frame until the emitter takes it.
// ----------------------------------------------------------------------------
module cfr_collect import cfr_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_stall,
  input  wire in_t    in_data,
  input  wire logic   frame_take,
  output logic        frame_valid,
  output frame_t      frame
);

  byte_t            store_r [FRAME_BYTES-1];
  logic [CNT_W-1:0] byte_cnt_r, byte_cnt_nxt;
  logic             disc_r, disc_nxt;
  logic             fvalid_r, fvalid_nxt;
  frame_t           frame_r;
  logic             acc;
  logic             complete;

  // stall only while a finished frame waits for the emitter
  assign in_stall = fvalid_r && !frame_take;
  assign acc      = in_valid && !in_stall;
  assign complete = acc && !disc_r && (byte_cnt_r == LAST_IDX);

  // count and burst drop control
  always_comb begin
    byte_cnt_nxt = byte_cnt_r;
    disc_nxt     = disc_r;
    fvalid_nxt   = fvalid_r && !frame_take;
    if (acc) begin
      if (disc_r) begin
        if (in_data.burst_end) disc_nxt = 1'b0;
      end else if (byte_cnt_r == LAST_IDX) begin
        byte_cnt_nxt = '0;
        disc_nxt     = !in_data.burst_end;
        fvalid_nxt   = 1'b1;
      end else begin
        byte_cnt_nxt = byte_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r <= '0;
      disc_r     <= 1'b0;
      fvalid_r   <= 1'b0;
    end else begin
      byte_cnt_r <= byte_cnt_nxt;
      disc_r     <= disc_nxt;
      fvalid_r   <= fvalid_nxt;
    end
  end

  // byte store and completed frame register
  always_ff @(posedge clk) begin
    if (acc && !disc_r && (byte_cnt_r != LAST_IDX)) begin
      store_r[byte_cnt_r] <= in_data.rx_byte;
    end
    if (complete) begin
      for (int i = 0; i < FRAME_BYTES - 1; i++) begin
        frame_r[i] <= store_r[i];
      end
      frame_r[FRAME_BYTES-1] <= in_data.rx_byte;
    end
  end

  assign frame_valid = fvalid_r;
  assign frame       = frame_r;

  // count rests at zero while a burst is dropped
  a_disc_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    disc_r |-> byte_cnt_r == '0)
    else $error("byte count moved while dropping a burst");

endmodule
`default_nettype wire

[sv/cfr_check.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_check
// Checks a completed frame (header, address, checksum), dispatches on the
// command byte and builds the response bytes with their checksum.
// ----------------------------------------------------------------------------
module cfr_check import cfr_pkg::*; (
  input  wire frame_t frame,
  input  wire byte_t  slave_addr,
  input  wire byte_t  key_seed,
  output desc_t       desc
);

  byte_t       sum;
  logic [15:0] key;
  logic [15:0] payload;
  byte_t       flag;

  // xor over the frame body, key derived from the seed
  always_comb begin
    sum = '0;
    for (int i = 0; i < FRAME_BYTES - 1; i++) begin
      sum = sum ^ frame[i];
    end
  end

  assign key     = ({8'd0, key_seed} * KEY_MUL) + KEY_ADD;
  assign payload = {frame[4], frame[5]};

  // checks in order, then command dispatch
  always_comb begin
    desc.event_res      = EVT_REJECT;
    desc.error_code     = ERR_NONE;
    desc.capacity_value = '0;
    desc.rsp            = 1'b0;
    flag                = FLAG_OK;
    if (frame[0] != HDR_FIRST || frame[1] != HDR_SECOND) begin
      desc.error_code = ERR_HEADER;
    end else if (frame[2] != slave_addr) begin
      desc.error_code = ERR_ADDRESS;
    end else if (sum != frame[FRAME_BYTES-1]) begin
      desc.error_code = ERR_CHECKSUM;
    end else begin
      case (frame[3])
        CMD_DATA: begin
          desc.event_res = (payload == 16'd0) ? EVT_REPORT : EVT_IGNORED;
        end
        CMD_ERASE: begin
          desc.rsp = 1'b1;
          if (key == payload) begin
            desc.event_res = EVT_CLEARED;
          end else begin
            desc.event_res = EVT_MISMATCH;
            flag           = FLAG_FAIL;
          end
        end
        CMD_CAPACITY: begin
          desc.rsp            = 1'b1;
          desc.event_res      = EVT_CAPACITY;
          desc.capacity_value = payload;
        end
        default: begin
          desc.event_res = EVT_IGNORED;
        end
      endcase
    end

    // response: request bytes 0..3, zero, flag, checksum
    desc.tx[0] = frame[0];
    desc.tx[1] = frame[1];
    desc.tx[2] = frame[2];
    desc.tx[3] = frame[3];
    desc.tx[4] = 8'h00;
    desc.tx[5] = flag;
    desc.tx[6] = frame[0] ^ frame[1] ^ frame[2] ^ frame[3] ^ flag;
  end

endmodule
`default_nettype wire

[sv/cfr_emit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_emit
// Holds one decoded frame and sends its results through the output
// register: one result for a plain event, seven for a response frame.
// ----------------------------------------------------------------------------
module cfr_emit import cfr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  frame_valid,
  input  wire desc_t desc,
  output logic       frame_take,
  output logic       out_valid,
  input  wire logic  out_stall,
  output out_t       out_data
);

  desc_t            desc_r;
  logic             active_r, active_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r;
  out_t             res;
  logic             out_free;
  logic             last_now;
  logic             finish;

  assign out_free   = !out_valid_r || !out_stall;
  assign last_now   = !desc_r.rsp || (cnt_r == LAST_IDX);
  assign finish     = active_r && out_free && last_now;
  assign frame_take = frame_valid && (!active_r || finish);

  // result for the current position
  always_comb begin
    res.event_res      = desc_r.event_res;
    res.error_code     = desc_r.error_code;
    res.capacity_value = desc_r.capacity_value;
    res.tx_valid       = desc_r.rsp;
    res.tx_byte        = desc_r.rsp ? desc_r.tx[cnt_r] : 8'h00;
    res.last           = last_now;
  end

  // sequencing
  always_comb begin
    active_nxt    = active_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (active_r && out_free) begin
      cnt_nxt       = cnt_r + 1'b1;
      out_valid_nxt = 1'b1;
    end
    if (finish) active_nxt = 1'b0;
    if (frame_take) begin
      active_nxt = 1'b1;
      cnt_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_take) desc_r <= desc;
    if (active_r && out_free) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_take_active: assert property (@(posedge clk) disable iff (!rst_n)
    frame_take |=> active_r && cnt_r == '0)
    else $error("taken frame did not start at position zero");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> cnt_r <= LAST_IDX)
    else $error("position ran past the frame");

  a_plain_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.tx_valid |-> out_data_r.last)
    else $error("plain event result without last");

  a_rsp_noerr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.tx_valid |-> out_data_r.error_code == ERR_NONE)
    else $error("response sent for a rejected frame");

endmodule
`default_nettype wire

[sv/command_frame_receiver_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// command_frame_receiver_unit
// Receives command frames byte by byte, checks and dispatches them, and
// reports events and response bytes.
//
//   channel | direction | ports                           | transaction
//   --------+-----------+---------------------------------+-----------------
//   in      | input     | in_valid, in_stall, in_data     | one received byte
//   out     | output    | out_valid, out_stall, out_data  | one result
//   cfg     | input     | cfg_we, cfg_idx, cfg_wdata      | register write
//
// A byte is taken every cycle while in_stall is low. After a frame's seventh
// byte is taken, its first result passes from the frame register through the
// decoded-frame holding register to the output register; results then follow
// one per cycle while out_stall is low: one result or seven for a response.
// The single decoded-frame holding register sets the rate: in_stall rises
// only while a finished frame waits behind an unfinished result sequence.
// Reset (synchronous, rst_n low) clears counters, valid flags and burst drop
// state and sets both registers to 1; no clearing pass. out_stall holds the
// output register; bytes still flow until a finished frame must wait in the frame register.
// ----------------------------------------------------------------------------
module command_frame_receiver_unit import cfr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire in_t   in_data,
  output logic       out_valid,
  input  wire logic  out_stall,
  output out_t       out_data,
  input  wire logic  cfg_we,
  input  wire logic  cfg_idx,
  input  wire byte_t cfg_wdata
);

  byte_t  slave_addr_r;
  byte_t  key_seed_r;
  logic   frame_valid;
  logic   frame_take;
  frame_t frame;
  desc_t  desc;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= 8'h01;
      key_seed_r   <= 8'h01;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_SLAVE_ADDR: slave_addr_r <= cfg_wdata;
        REG_KEY_SEED:   key_seed_r   <= cfg_wdata;
        default:        slave_addr_r <= slave_addr_r;
      endcase
    end
  end

  cfr_collect u_collect (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .frame_take  (frame_take),
    .frame_valid (frame_valid),
    .frame       (frame)
  );

  cfr_check u_check (
    .frame      (frame),
    .slave_addr (slave_addr_r),
    .key_seed   (key_seed_r),
    .desc       (desc)
  );

  cfr_emit u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_valid (frame_valid),
    .desc        (desc),
    .frame_take  (frame_take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
`default_nettype wire

[test/tb_command_frame_receiver_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_command_frame_receiver_unit
// Self-checking bench for the command frame receiver. A short scripted byte
// sequence is followed by random command frames, built whole and then
// corrupted or left intact, under several register settings. Every result
// is compared against a behavioral predictor or scripted value. Both handshakes
// idle at random, and one long output hold makes the block back up its input.
// ----------------------------------------------------------------------------
module tb_command_frame_receiver_unit;
  import cfr_pkg::*;

  localparam int BYTES_PER_PHASE = 70;
  localparam int NUM_PHASES      = 6;
  localparam int SETTLE_CYCLES   = 8;
  localparam int LONG_HOLD       = 200;
  localparam int REPORT_LIMIT    = 10;

  // one scripted byte, with a hand-written result where it is obvious
  typedef struct packed {
    byte_t rx;
    logic  burst_last;
    logic  typed;
    evt_t  ev;
    err_t  err;
  } script_row_t;

  localparam int SCRIPT_LEN = 23;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // bad header, extreme bytes, frame closes mid-burst
    '{8'h00, 1'b1, 1'b0, EVT_REJECT, ERR_NONE},
    '{8'hFF, 1'b0, 1'b0, EVT_REJECT, ERR_NONE},
    '{8'hFF, 1'b1, 1'b0, EVT_REJECT, ERR_NONE},
    '{8'hFF, 1'b0, 1'b0, EVT_REJECT, ERR_NONE},
    '{8'hFF, 1'b0, 1'b0, EVT_REJECT, ERR_NONE},
    '{8'hFF, 1'b0, 1'b0, EVT_REJECT, ERR_NONE},
    '{8'hFF, 1'b0, 1'b1, EVT_REJECT, ERR_HEADER},
    // rest of the burst is dropped
    '{8'hAA, 1'b0, 1'b0, EVT_REJECT, ERR_NONE},
    '{8'h55, 1'b1, 1'b0, EVT_REJECT, ERR_NONE},
    // fault erase with the key of the reset seed
    '{8'h07, 1'b0, 1'b0, EVT_REJECT, ERR_NONE},
    '{8'hE0, 1'b0, 1'b0, EVT_REJECT, ERR_NONE},
    '{8'h01, 1'b0, 1'b0, EVT_REJECT, ERR_NONE},
    '{8'hF0, 1'b0, 1'b0, EVT_REJECT, ERR_NONE},
    '{8'hA7, 1'b0, 1'b0, EVT_REJECT, ERR_NONE},
    '{8'hC9, 1'b0, 1'b0, EVT_REJECT, ERR_NONE},
    '{8'h78, 1'b1, 1'b0, EVT_REJECT, ERR_NONE},
    // data request with empty payload
    '{8'h07, 1'b0, 1'b0, EVT_REJECT, ERR_NONE},
    '{8'hE0, 1'b0, 1'b0, EVT_REJECT, ERR_NONE},
    '{8'h01, 1'b0, 1'b0, EVT_REJECT, ERR_NONE},
    '{8'hFF, 1'b0, 1'b0, EVT_REJECT, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, EVT_REJECT, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, EVT_REJECT, ERR_NONE},
    '{8'h19, 1'b1, 1'b1, EVT_REPORT, ERR_NONE}
  };

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  in_t      in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_t     out_data;
  logic     cfg_we    = 1'b0;
  cfg_reg_t cfg_idx   = REG_SLAVE_ADDR;
  byte_t    cfg_wdata = '0;

  // predictor state
  byte_t  pred_addr;
  byte_t  pred_seed;
  frame_t pred_frame;
  int     pred_count;
  bit     pred_dropping;

  out_t awaited_results[$];
  int   mismatches    = 0;
  int   bytes_framed  = 0;
  bit   calm_tx       = 1'b0;
  bit   calm_rx       = 1'b0;
  bit   long_hold_req = 1'b0;
  frame_t gen_frame;

  command_frame_receiver_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic byte_t xor_head(frame_t f);
    byte_t x;
    x = '0;
    for (int i = 0; i < FRAME_BYTES - 1; i++) x ^= f[i];
    return x;
  endfunction

  function automatic logic [15:0] erase_key(byte_t seed);
    logic [31:0] prod;
    prod = 32'(seed) * 32'(KEY_MUL) + 32'(KEY_ADD);
    return prod[15:0];
  endfunction

  function automatic void push_single(evt_t ev, err_t err);
    out_t r;
    r = '0;
    r.event_res  = ev;
    r.error_code = err;
    r.last       = 1'b1;
    awaited_results.push_back(r);
  endfunction

  function automatic void push_reply(evt_t ev, logic [15:0] cap, byte_t flag, frame_t f);
    frame_t rsp;
    out_t   r;
    rsp    = f;
    rsp[4] = 8'h00;
    rsp[5] = flag;
    rsp[6] = xor_head(rsp);
    for (int k = 0; k < FRAME_BYTES; k++) begin
      r.event_res      = ev;
      r.error_code     = ERR_NONE;
      r.capacity_value = cap;
      r.tx_valid       = 1'b1;
      r.tx_byte        = rsp[k];
      r.last           = (k == FRAME_BYTES - 1);
      awaited_results.push_back(r);
    end
  endfunction

  // collect one byte; returns 1 when the byte was framed, 0 when dropped
  function automatic bit predict_byte(in_t v);
    logic [15:0] payload;
    if (pred_dropping) begin
      if (v.burst_end) pred_dropping = 1'b0;
      return 1'b0;
    end
    pred_frame[pred_count] = v.rx_byte;
    pred_count++;
    if (pred_count < FRAME_BYTES) return 1'b1;
    pred_count    = 0;
    pred_dropping = !v.burst_end;
    payload = {pred_frame[4], pred_frame[5]};
    if (pred_frame[0] != HDR_FIRST || pred_frame[1] != HDR_SECOND)
      push_single(EVT_REJECT, ERR_HEADER);
    else if (pred_frame[2] != pred_addr)
      push_single(EVT_REJECT, ERR_ADDRESS);
    else if (xor_head(pred_frame) != pred_frame[6])
      push_single(EVT_REJECT, ERR_CHECKSUM);
    else begin
      case (pred_frame[3])
        CMD_DATA:     push_single(payload == 16'h0 ? EVT_REPORT : EVT_IGNORED, ERR_NONE);
        CMD_ERASE: begin
          if (payload == erase_key(pred_seed))
            push_reply(EVT_CLEARED, 16'h0, FLAG_OK, pred_frame);
          else
            push_reply(EVT_MISMATCH, 16'h0, FLAG_FAIL, pred_frame);
        end
        CMD_CAPACITY: push_reply(EVT_CAPACITY, payload, FLAG_OK, pred_frame);
        default:      push_single(EVT_IGNORED, ERR_NONE);
      endcase
    end
    return 1'b1;
  endfunction

  // offer one byte, wait for the transaction, update the predictor
  task automatic send_byte(in_t v, logic typed, evt_t ev, err_t err);
    int gap;
    int mark;
    gap = calm_tx ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= v;
    do @(posedge clk); while (in_stall);
    mark = awaited_results.size();
    if (predict_byte(v)) bytes_framed++;
    if (typed) begin
      while (awaited_results.size() > mark)
        awaited_results.delete(awaited_results.size() - 1);
      push_single(ev, err);
    end
    @(negedge clk);
  endtask

  task automatic send_plain(byte_t b, logic burst_last);
    in_t v;
    v.rx_byte   = b;
    v.burst_end = burst_last;
    send_byte(v, 1'b0, EVT_REJECT, ERR_NONE);
  endtask

  // quiet the input and let every awaited result drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, byte_t val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    if (idx == REG_SLAVE_ADDR) pred_addr = val;
    else pred_seed = val;
  endtask

  // build one frame: mostly well formed, some corrupted or pure noise
  function automatic void compose_frame();
    int     kind;
    int     sel;
    logic [15:0] payload;
    kind = $urandom_range(0, 13);
    sel  = $urandom_range(0, 3);
    payload = (sel == 0) ? 16'h0000 : (sel == 1) ? 16'hFFFF : 16'($urandom);
    gen_frame[0] = HDR_FIRST;
    gen_frame[1] = HDR_SECOND;
    gen_frame[2] = pred_addr;
    gen_frame[3] = CMD_CAPACITY;
    case (kind)
      0, 1, 12: begin
        gen_frame[3] = CMD_ERASE;
        payload = erase_key(pred_seed);
      end
      2:        gen_frame[3] = CMD_ERASE;
      5:        begin
        gen_frame[3] = CMD_DATA;
        payload = 16'h0000;
      end
      6:        gen_frame[3] = CMD_DATA;
      7:        gen_frame[3] = 8'($urandom);
      default:  ;
    endcase
    gen_frame[4] = payload[15:8];
    gen_frame[5] = payload[7:0];
    if (kind == 9) gen_frame[2] = pred_addr ^ 8'($urandom_range(1, 255));
    gen_frame[6] = xor_head(gen_frame);
    case (kind)
      8:  gen_frame[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
      10: gen_frame[6] ^= 8'($urandom_range(1, 255));
      11: gen_frame = frame_t'({$urandom, $urandom});
      default: ;
    endcase
  endfunction

  task automatic send_random_frame();
    if ($urandom_range(0, 5) == 0) calm_tx = !calm_tx;
    compose_frame();
    for (int i = 0; i < FRAME_BYTES - 1; i++)
      send_plain(gen_frame[i], $urandom_range(0, 3) == 0);
    send_plain(gen_frame[FRAME_BYTES - 1], $urandom_range(0, 2) != 0);
    // bytes dropped after a frame closed mid-burst
    while (pred_dropping)
      send_plain(8'($urandom), $urandom_range(0, 2) == 0);
  endtask

  // output side: random hold per transaction, one long hold on request
  initial begin : result_sink
    int hold;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 15) == 0) calm_rx = !calm_rx;
      if (long_hold_req) begin
        hold = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        hold = calm_rx ? 0 : $urandom_range(0, 7);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // result checker
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("unexpected result: ev=%0d err=%0d cap=%h txv=%b txb=%h last=%b",
                   out_data.event_res, out_data.error_code, out_data.capacity_value,
                   out_data.tx_valid, out_data.tx_byte, out_data.last);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (out_data.event_res !== want.event_res ||
            out_data.error_code !== want.error_code ||
            out_data.capacity_value !== want.capacity_value ||
            out_data.tx_valid !== want.tx_valid ||
            out_data.tx_byte !== want.tx_byte ||
            out_data.last !== want.last) begin
          if (mismatches < REPORT_LIMIT) begin
            $display("mismatch: want ev=%0d err=%0d cap=%h txv=%b txb=%h last=%b",
                     want.event_res, want.error_code, want.capacity_value,
                     want.tx_valid, want.tx_byte, want.last);
            $display("          got  ev=%0d err=%0d cap=%h txv=%b txb=%h last=%b",
                     out_data.event_res, out_data.error_code, out_data.capacity_value,
                     out_data.tx_valid, out_data.tx_byte, out_data.last);
          end
          mismatches++;
        end
      end
    end
  end

  // main sequence
  initial begin : stimulus
    in_t   v;
    byte_t addr_set [NUM_PHASES];
    byte_t seed_set [NUM_PHASES];
    addr_set = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom), 8'h01, 8'($urandom)};
    seed_set = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom), 8'($urandom), 8'hFF};
    pred_addr     = 8'h01;
    pred_seed     = 8'h01;
    pred_frame    = '0;
    pred_count    = 0;
    pred_dropping = 1'b0;

    // reset
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // scripted bytes at reset register values
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      v.rx_byte   = SCRIPT[i].rx;
      v.burst_end = SCRIPT[i].burst_last;
      send_byte(v, SCRIPT[i].typed, SCRIPT[i].ev, SCRIPT[i].err);
    end

    // random frames under each register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      write_reg(REG_SLAVE_ADDR, addr_set[ph]);
      write_reg(REG_KEY_SEED, seed_set[ph]);
      cfg_we <= 1'b0;
      @(negedge clk);
      if (ph == 2) long_hold_req = 1'b1;
      bytes_framed = 0;
      while (bytes_framed < BYTES_PER_PHASE) send_random_frame();
    end
    wait_idle();

    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
